[hdl/frc_pkg.sv]
`timescale 1ns / 1ps
// frc_pkg: shared types and constants of the frame buffer recycler
// no dependencies; used by frc_store, frame_buffer_recycler_core and frc_checker

package frc_pkg;

    localparam int ID_W    = 3;
    localparam int OP_W    = 2;
    localparam int KEEP_W  = 4;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 16;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd1;

    // output item bit positions, lowest first
    localparam int O_REC_V   = 0;
    localparam int O_REC_ID  = 1;
    localparam int O_FETCH_V = 4;
    localparam int O_FETCH_ID = 5;
    localparam int O_EMPTY   = 8;
    localparam int O_OVF     = 9;

    typedef enum logic [OP_W-1:0] {
        OP_DELIVER = 2'd0,
        OP_FETCH   = 2'd1,
        OP_RETURN  = 2'd2,
        OP_IGNORE  = 2'd3
    } op_t;

    // where the pending read data goes
    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_PROC  = 2'd1,
        SRC_DELIV = 2'd2,
        SRC_FETCH = 2'd3
    } src_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    // what the accept cycle leaves for the read cycle
    typedef struct packed {
        src_t            src;
        logic            fwd;
        logic [ID_W-1:0] id;
        logic            empty;
        logic            ovf;
    } pend_t;

endpackage

[hdl/frc_store.sv]
`timescale 1ns / 1ps
// frc_store: single-port-write, single-port-read handle memory, registered read
// depends on frc_pkg for the handle width

module frc_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [frc_pkg::ID_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [frc_pkg::ID_W-1:0] rd_data
);
    import frc_pkg::*;

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/frame_buffer_recycler_core.sv]
`timescale 1ns / 1ps
// Frame buffer recycler: keeps a delivered deque and a processed fifo of buffer
// handles in two synchronous memories (frc_store) and answers each event with one item.
// In each item the accept cycle updates the head and count registers and issues the memory
// reads and writes; in the read state the registered read data is taken into the output
// register once it is free or drained, and no new item is accepted until then. A handle
// recycled from a delivered deque that was empty before the item is forwarded from the
// input. keep_count resets to 1 and is written through the cfg channel; the user must
// write it only while the block is idle, as the block itself does not enforce this.

module frame_buffer_recycler_core #(
    parameter int BUFFERS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [frc_pkg::IN_W-1:0]  s_tdata,   // [2:0] buffer_id, rest zero
    input  logic [frc_pkg::OP_W-1:0]  s_tuser,   // [1:0] op
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [frc_pkg::OUT_W-1:0] m_tdata,   // recycle_valid, recycle_id[3], fetch_valid,
                                                 // fetch_id[3], fetch_empty, overflow, zero pad
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [frc_pkg::KEEP_W-1:0] cfg_data  // keep_count
);
    import frc_pkg::*;

    localparam int AW = $clog2(BUFFERS);
    localparam int CW = $clog2(BUFFERS + 1);
    localparam int SW = AW + 1;
    localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(BUFFERS);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFERS);

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [AW-1:0] r;
        if (s >= DEPTH_S)
        begin
            r = AW'(s - DEPTH_S);
        end
        else
        begin
            r = AW'(s);
        end
        return r;
    endfunction

    state_t           state_reg, state_next;
    logic [AW-1:0]    d_head_reg, d_head_next, p_head_reg, p_head_next;
    logic [CW-1:0]    d_cnt_reg, d_cnt_next, p_cnt_reg, p_cnt_next;
    logic [KEEP_W-1:0] keep_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    pend_t            pend_reg, pend_next;

    logic             accept, load;
    logic [ID_W-1:0]  in_id;
    op_t              in_op;
    logic             d_full, p_full;
    logic [CW-1:0]    d_cnt_push;
    logic [AW-1:0]    d_tail, d_newest, p_tail;
    logic             d_wr_en, p_wr_en, d_rd_en, p_rd_en;
    logic [AW-1:0]    d_rd_addr;
    logic [ID_W-1:0]  d_rd_data, p_rd_data;
    logic [ID_W-1:0]  rec_id, fetch_id;

    assign in_id  = s_tdata[ID_W-1:0];
    assign in_op  = op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign d_full   = (d_cnt_reg == DEPTH_C);
    assign p_full   = (p_cnt_reg == DEPTH_C);
    assign d_tail   = wrap(SW'(d_head_reg) + SW'(d_cnt_reg));
    assign d_newest = wrap(SW'(d_head_reg) + SW'(d_cnt_reg) - SW'(1));
    assign p_tail   = wrap(SW'(p_head_reg) + SW'(p_cnt_reg));
    assign d_cnt_push = d_full ? d_cnt_reg : d_cnt_reg + CW'(1);

    always_comb
    begin
        d_head_next = d_head_reg;
        p_head_next = p_head_reg;
        d_cnt_next  = d_cnt_reg;
        p_cnt_next  = p_cnt_reg;
        pend_next   = pend_reg;
        d_wr_en     = 1'b0;
        p_wr_en     = 1'b0;
        d_rd_en     = 1'b0;
        p_rd_en     = 1'b0;
        d_rd_addr   = d_head_reg;
        if (accept)
        begin
            pend_next.src   = SRC_NONE;
            pend_next.fwd   = 1'b0;
            pend_next.id    = in_id;
            pend_next.empty = 1'b0;
            pend_next.ovf   = 1'b0;
            unique case (in_op)
                OP_DELIVER:
                begin
                    d_wr_en       = !d_full;
                    pend_next.ovf = d_full;
                    d_cnt_next    = d_cnt_push;
                    if (p_cnt_reg != '0)
                    begin
                        p_rd_en       = 1'b1;
                        pend_next.src = SRC_PROC;
                        p_head_next   = wrap(SW'(p_head_reg) + SW'(1));
                        p_cnt_next    = p_cnt_reg - CW'(1);
                    end
                    else if (KW'(d_cnt_push) > KW'(keep_reg))
                    begin
                        d_rd_en       = 1'b1;
                        pend_next.src = SRC_DELIV;
                        // the handle written this cycle is the one recycled
                        pend_next.fwd = (d_cnt_reg == '0);
                        d_head_next   = wrap(SW'(d_head_reg) + SW'(1));
                        d_cnt_next    = d_cnt_push - CW'(1);
                    end
                end
                OP_FETCH:
                begin
                    if (d_cnt_reg == '0)
                    begin
                        pend_next.empty = 1'b1;
                    end
                    else
                    begin
                        d_rd_en       = 1'b1;
                        d_rd_addr     = d_newest;
                        pend_next.src = SRC_FETCH;
                        d_cnt_next    = d_cnt_reg - CW'(1);
                    end
                end
                OP_RETURN:
                begin
                    p_wr_en       = !p_full;
                    pend_next.ovf = p_full;
                    p_cnt_next    = p_full ? p_cnt_reg : p_cnt_reg + CW'(1);
                end
                OP_IGNORE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    frc_store #(
        .DEPTH (BUFFERS),
        .AW    (AW)
    ) u_deliv (
        .clk     (clk),
        .wr_en   (d_wr_en),
        .wr_addr (d_tail),
        .wr_data (in_id),
        .rd_en   (d_rd_en),
        .rd_addr (d_rd_addr),
        .rd_data (d_rd_data)
    );

    frc_store #(
        .DEPTH (BUFFERS),
        .AW    (AW)
    ) u_proc (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (p_tail),
        .wr_data (in_id),
        .rd_en   (p_rd_en),
        .rd_addr (p_head_reg),
        .rd_data (p_rd_data)
    );

    // result assembly in the read cycle
    always_comb
    begin
        rec_id   = '0;
        fetch_id = '0;
        unique case (pend_reg.src)
            SRC_PROC:  rec_id = p_rd_data;
            SRC_DELIV: rec_id = pend_reg.fwd ? pend_reg.id : d_rd_data;
            SRC_FETCH: fetch_id = d_rd_data;
            SRC_NONE:  rec_id = '0;
            default:   rec_id = '0;
        endcase
    end

    assign load = (state_reg == S_READ) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[O_REC_V] = (pend_reg.src == SRC_PROC) ||
                                             (pend_reg.src == SRC_DELIV);
                    out_data_next[O_REC_ID +: ID_W]   = rec_id;
                    out_data_next[O_FETCH_V]          = (pend_reg.src == SRC_FETCH);
                    out_data_next[O_FETCH_ID +: ID_W] = fetch_id;
                    out_data_next[O_EMPTY]            = pend_reg.empty;
                    out_data_next[O_OVF]              = pend_reg.ovf;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            d_head_reg    <= '0;
            p_head_reg    <= '0;
            d_cnt_reg     <= '0;
            p_cnt_reg     <= '0;
            keep_reg      <= KEEP_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            d_head_reg    <= d_head_next;
            p_head_reg    <= p_head_next;
            d_cnt_reg     <= d_cnt_next;
            p_cnt_reg     <= p_cnt_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                keep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hdl/frc_checker.sv]
`timescale 1ns / 1ps
// frc_checker: port-level checks of frame_buffer_recycler_core, bound to the top level
// depends on frc_pkg for widths and output bit positions

module frc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [frc_pkg::OUT_W-1:0] m_tdata
);
    import frc_pkg::*;

    // a result waiting for the sink is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // an item is worked on one at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // with a free output register the read state loads the result into it after accept
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!m_tvalid || m_tready) |-> ##2 m_tvalid)
        else $error("result missing two cycles after item");

    // one item never carries two kinds of answer, and pad bits stay zero
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones({m_tdata[O_REC_V], m_tdata[O_FETCH_V],
                                  m_tdata[O_EMPTY]}) <= 1)
                     && (m_tdata[OUT_W-1:O_OVF+1] == '0))
        else $error("conflicting result flags");

endmodule

bind frame_buffer_recycler_core frc_checker u_frc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
